FILE: hdl/qet_pkg.sv
// ----------------------------------------------------------------------------
// qet_pkg
// Types and constants shared by the quadratic easing tween modules.
// ----------------------------------------------------------------------------
package qet_pkg;

  localparam int ELAPSED_W  = 33;
  localparam int DUR_W      = 32;
  localparam int STEP_W     = 16;
  localparam int FRAC_W     = 18;
  localparam int LANE_W     = 32;
  localparam int DIFF_W     = LANE_W + 1;
  localparam int WGT_W      = 24;
  localparam int MUL_W      = DIFF_W + WGT_W;
  localparam int W32_W      = 40;
  localparam int SUM_W      = MUL_W - 16 + 1;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int MASK_W     = 4;
  localparam int KIND_W     = 3;
  localparam int DIVCNT_W   = $clog2(FRAC_W);

  localparam logic [CFG_IDX_W-1:0] REG_START_XY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ZW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_XY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_ZW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EASE_KIND   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_KIND = 3'd6;

  localparam logic [MASK_W-1:0] MASK_NONE = 4'h0;
  localparam logic [MASK_W-1:0] MASK_XYZ  = 4'h7;
  localparam logic [MASK_W-1:0] MASK_W_ONLY = 4'h8;
  localparam logic [MASK_W-1:0] MASK_ALL  = 4'hF;

  typedef enum logic [KIND_W-1:0] {
    EASE_NONE   = 3'd0,
    EASE_LINEAR = 3'd1,
    EASE_IN     = 3'd2,
    EASE_OUT    = 3'd3,
    EASE_INOUT  = 3'd4
  } qet_ease_t;

  typedef enum logic [KIND_W-1:0] {
    TGT_MOVE    = 3'd0,
    TGT_MOVE_TO = 3'd1,
    TGT_SCALE   = 3'd2,
    TGT_ROTATE  = 3'd3,
    TGT_COLOUR  = 3'd4,
    TGT_ALPHA   = 3'd5,
    TGT_RGBA    = 3'd6
  } qet_target_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQR,
    ST_WGT,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } qet_state_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] start_xy;
    logic [CFG_DATA_W-1:0] start_zw;
    logic [CFG_DATA_W-1:0] end_xy;
    logic [CFG_DATA_W-1:0] end_zw;
    logic [DUR_W-1:0]      duration;
    logic [KIND_W-1:0]     ease_kind;
    logic [KIND_W-1:0]     target_kind;
  } qet_cfg_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed;
    logic                 finished;
    logic [MASK_W-1:0]    mask;
    logic                 ease_ok;
    qet_ease_t            ease;
  } qet_item_t;

  function automatic logic [DUR_W-1:0] eff_duration(input logic [DUR_W-1:0] d);
    logic [DUR_W-1:0] r;
    r = (d == '0) ? DUR_W'(1) : d;
    return r;
  endfunction

endpackage

FILE: hdl/qet_front.sv
// ----------------------------------------------------------------------------
// qet_front
// Accumulates elapsed time per item, flags completion and picks lane mask.
// ----------------------------------------------------------------------------
module qet_front (
  input  logic                     clk,
  input  logic                     rst,
  input  qet_pkg::qet_cfg_t        cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [qet_pkg::STEP_W-1:0] time_step,
  input  logic                     q_full,
  output logic                     push,
  output qet_pkg::qet_item_t       push_item
);
  import qet_pkg::*;

  logic [ELAPSED_W-1:0] elapsed;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [ELAPSED_W:0]   sum;
  logic [DUR_W-1:0]     dur;
  logic [MASK_W-1:0]    mask;
  logic                 ease_ok;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign dur      = eff_duration(cfg.duration);

  // saturating accumulate
  always_comb begin
    sum = {1'b0, elapsed} + (ELAPSED_W + 1)'(time_step);
    elapsed_next = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
  end

  always_comb begin
    case (qet_target_t'(cfg.target_kind))
      TGT_MOVE, TGT_MOVE_TO, TGT_COLOUR: mask = MASK_XYZ;
      TGT_ALPHA:                         mask = MASK_W_ONLY;
      TGT_RGBA:                          mask = MASK_ALL;
      default:                           mask = MASK_NONE;
    endcase
  end

  always_comb begin
    case (qet_ease_t'(cfg.ease_kind))
      EASE_LINEAR, EASE_IN, EASE_OUT, EASE_INOUT: ease_ok = 1'b1;
      default:                                    ease_ok = 1'b0;
    endcase
  end

  always_comb begin
    push_item.elapsed  = elapsed_next;
    push_item.finished = elapsed_next > ELAPSED_W'(dur);
    push_item.mask     = mask;
    push_item.ease_ok  = ease_ok;
    push_item.ease     = qet_ease_t'(cfg.ease_kind);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (push) begin
      elapsed <= elapsed_next;
    end
  end

endmodule

FILE: hdl/qet_fifo.sv
// ----------------------------------------------------------------------------
// qet_fifo
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module qet_fifo #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qet_pkg::qet_item_t push_item,
  output logic               full,
  input  logic               pop,
  output qet_pkg::qet_item_t head,
  output logic               head_valid
);
  import qet_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qet_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

FILE: hdl/qet_back.sv
// ----------------------------------------------------------------------------
// qet_back
// Serial divider for the time fraction, shared multiplier for the eased
// weight and the four lanes, and the output register.
// ----------------------------------------------------------------------------
module qet_back (
  input  logic                          clk,
  input  logic                          rst,
  input  qet_pkg::qet_cfg_t             cfg,
  input  qet_pkg::qet_item_t            head,
  input  logic                          head_valid,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [qet_pkg::LANE_W-1:0] lane_x,
  output logic signed [qet_pkg::LANE_W-1:0] lane_y,
  output logic signed [qet_pkg::LANE_W-1:0] lane_z,
  output logic signed [qet_pkg::LANE_W-1:0] lane_w,
  output logic [qet_pkg::MASK_W-1:0]    apply_mask,
  output logic                          finished
);
  import qet_pkg::*;

  localparam logic signed [W32_W-1:0] ONE_Q32 = 40'sh01_0000_0000;

  qet_state_t state;
  qet_state_t state_next;

  qet_item_t             cur;
  logic [DUR_W:0]        rem;
  logic [FRAC_W-1:0]     nbits;
  logic [FRAC_W-1:0]     quo;
  logic                  ovf;
  logic [DIVCNT_W-1:0]   div_cnt;
  logic [FRAC_W-1:0]     frac;
  logic signed [WGT_W-1:0] w16;
  logic signed [MUL_W-1:0] prod;
  logic [1:0]            lane_idx;
  logic [LANE_W-1:0]     lane_res [4];

  logic [DUR_W-1:0]      dur;
  logic [DUR_W:0]        trial;
  logic                  trial_ge;
  logic [FRAC_W-1:0]     t_eff;
  logic [LANE_W-1:0]     s_sel;
  logic [LANE_W-1:0]     e_sel;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] mul_a;
  logic signed [WGT_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  prod_c;
  logic signed [W32_W-1:0]  f40;
  logic signed [W32_W-1:0]  sq40;
  logic signed [W32_W-1:0]  w32;
  logic signed [SUM_W-1:0]  lane_sum;
  logic [LANE_W-1:0]        lane_sat;
  logic out_free;
  logic div_load;
  logic div_step;
  logic sqr_load;
  logic wgt_load;
  logic mul_load;
  logic acc_load;
  logic out_load;

  assign dur      = eff_duration(cfg.duration);
  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (head_valid) state_next = ST_DIV;
      ST_DIV:  if (div_cnt == DIVCNT_W'(FRAC_W - 1)) state_next = ST_SQR;
      ST_SQR:  state_next = ST_WGT;
      ST_WGT:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = (lane_idx == 2'd3) ? ST_DONE : ST_MUL;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    div_load = 1'b0;
    div_step = 1'b0;
    sqr_load = 1'b0;
    wgt_load = 1'b0;
    mul_load = 1'b0;
    acc_load = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: div_load = head_valid;
      ST_DIV:  div_step = 1'b1;
      ST_SQR:  sqr_load = 1'b1;
      ST_WGT:  wgt_load = 1'b1;
      ST_MUL:  mul_load = 1'b1;
      ST_ACC:  acc_load = 1'b1;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign pop = div_load;

  // restoring division step
  always_comb begin
    trial    = {rem[DUR_W-1:0], nbits[FRAC_W-1]};
    trial_ge = trial >= {1'b0, dur};
    t_eff    = ovf ? '1 : quo;
  end

  // lane operand select
  always_comb begin
    case (lane_idx)
      2'd0:    begin s_sel = cfg.start_xy[31:0];  e_sel = cfg.end_xy[31:0];  end
      2'd1:    begin s_sel = cfg.start_xy[63:32]; e_sel = cfg.end_xy[63:32]; end
      2'd2:    begin s_sel = cfg.start_zw[31:0];  e_sel = cfg.end_zw[31:0];  end
      default: begin s_sel = cfg.start_zw[63:32]; e_sel = cfg.end_zw[63:32]; end
    endcase
    diff = $signed({e_sel[LANE_W-1], e_sel}) - $signed({s_sel[LANE_W-1], s_sel});
  end

  // shared multiplier
  always_comb begin
    if (state == ST_SQR) begin
      mul_a = $signed(DIFF_W'(t_eff));
      mul_b = $signed(WGT_W'(t_eff));
    end else begin
      mul_a = diff;
      mul_b = w16;
    end
    prod_c = mul_a * mul_b;
  end

  // eased weight in q.32
  always_comb begin
    f40  = $signed(W32_W'(frac));
    sq40 = $signed(W32_W'(prod[2*FRAC_W-1:0]));
    case (cur.ease)
      EASE_LINEAR: w32 = f40 <<< 16;
      EASE_IN:     w32 = sq40;
      EASE_OUT:    w32 = (f40 <<< 17) - sq40;
      EASE_INOUT: begin
        if (frac[FRAC_W-1:15] == '0) w32 = sq40 <<< 1;
        else w32 = (f40 <<< 18) - (sq40 <<< 1) - ONE_Q32;
      end
      default:     w32 = '0;
    endcase
  end

  // lane add and saturate
  always_comb begin
    lane_sum = $signed({prod[MUL_W-1], prod[MUL_W-1:16]})
             + $signed(SUM_W'($signed(s_sel)));
    if (lane_sum[SUM_W-1:LANE_W-1] == {(SUM_W - LANE_W + 1){lane_sum[SUM_W-1]}}) begin
      lane_sat = lane_sum[LANE_W-1:0];
    end else begin
      lane_sat = lane_sum[SUM_W-1] ? {1'b1, {(LANE_W-1){1'b0}}}
                                   : {1'b0, {(LANE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      cur     <= head;
      rem     <= {2'b00, head.elapsed[ELAPSED_W-1:2]};
      nbits   <= {head.elapsed[1:0], 16'h0000};
      ovf     <= {1'b0, head.elapsed} >= {dur, 2'b00};
      div_cnt <= '0;
    end
    if (div_step) begin
      rem     <= trial_ge ? trial - {1'b0, dur} : trial;
      quo     <= {quo[FRAC_W-2:0], trial_ge};
      nbits   <= {nbits[FRAC_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
    if (sqr_load) begin
      frac <= t_eff;
      prod <= prod_c;
    end
    if (wgt_load) begin
      w16      <= w32[W32_W-1:16];
      lane_idx <= 2'd0;
    end
    if (mul_load) begin
      prod <= prod_c;
    end
    if (acc_load) begin
      lane_res[lane_idx] <= lane_sat;
      lane_idx           <= lane_idx + 1'b1;
    end
    if (out_load) begin
      lane_x     <= cur.ease_ok ? $signed(lane_res[0]) : '0;
      lane_y     <= cur.ease_ok ? $signed(lane_res[1]) : '0;
      lane_z     <= cur.ease_ok ? $signed(lane_res[2]) : '0;
      lane_w     <= cur.ease_ok ? $signed(lane_res[3]) : '0;
      apply_mask <= cur.mask;
      finished   <= cur.finished;
    end
  end

  a_rem_below_dur: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !ovf) |-> rem < {1'b0, dur})
    else $error("divider remainder not below duration");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && head_valid))
    else $error("item taken outside idle");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished item not presented");

endmodule

FILE: hdl/quadratic_easing_tween.sv
// ----------------------------------------------------------------------------
// quadratic_easing_tween
// Quadratic easing tween over four Q16.16 lanes, one result per tick item.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one time_step per tick item; output
// channel out_valid/out_stall returns the four lanes, apply_mask and finished.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, and the block itself does not enforce this.
// The front adds time_step to the elapsed-time accumulator in the cycle it
// accepts the item and queues it. The back takes one item at a time: it
// picks it up, runs the bit-serial fraction divider, forms the weight (one
// multiply), processes the four lanes on the shared multiplier and loads the
// output register. It takes no new item until its result is loaded, which
// bounds the sustained rate by the divider and the single multiplier.
// The queue lets the front take further items while the back is busy; a
// stalled result sits in the output register and the back waits on it.
// Reset clears the accumulator, queue and output valid, and sets registers
// to their defaults (duration 1, linear easing, move target).
// ----------------------------------------------------------------------------
module quadratic_easing_tween #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [qet_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qet_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [qet_pkg::STEP_W-1:0]        time_step,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [qet_pkg::LANE_W-1:0] lane_x,
  output logic signed [qet_pkg::LANE_W-1:0] lane_y,
  output logic signed [qet_pkg::LANE_W-1:0] lane_z,
  output logic signed [qet_pkg::LANE_W-1:0] lane_w,
  output logic [qet_pkg::MASK_W-1:0]        apply_mask,
  output logic                              finished
);
  import qet_pkg::*;

  qet_cfg_t  cfg;
  qet_item_t push_item;
  qet_item_t head;
  logic      push;
  logic      q_full;
  logic      pop;
  logic      head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_xy    <= '0;
      cfg.start_zw    <= '0;
      cfg.end_xy      <= '0;
      cfg.end_zw      <= '0;
      cfg.duration    <= DUR_W'(1);
      cfg.ease_kind   <= EASE_LINEAR;
      cfg.target_kind <= TGT_MOVE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_XY:    cfg.start_xy    <= cfg_data;
        REG_START_ZW:    cfg.start_zw    <= cfg_data;
        REG_END_XY:      cfg.end_xy      <= cfg_data;
        REG_END_ZW:      cfg.end_zw      <= cfg_data;
        REG_DURATION:    cfg.duration    <= cfg_data[DUR_W-1:0];
        REG_EASE_KIND:   cfg.ease_kind   <= cfg_data[KIND_W-1:0];
        REG_TARGET_KIND: cfg.target_kind <= cfg_data[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  qet_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .time_step (time_step),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  qet_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  qet_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .lane_x     (lane_x),
    .lane_y     (lane_y),
    .lane_z     (lane_z),
    .lane_w     (lane_w),
    .apply_mask (apply_mask),
    .finished   (finished)
  );

endmodule
